>>> design/brca_pkg.sv
// ----------------------------------------------------------------------------
// brca_pkg: shared types and constants for the blit rectangle clip unit
// Field widths, the configuration register map and saturation helpers.
// ----------------------------------------------------------------------------
package brca_pkg;

  localparam int SIZE_W    = 15;  // image size in pixels, up to 16384
  localparam int PIX_W     = 14;  // pixel coordinate inside an image
  localparam int BPP_W     = 5;   // bytes per pixel register
  localparam int SPAN_W    = 19;  // row bytes, up to 262144
  localparam int PITCH_W   = 18;
  localparam int MUL_W     = PIX_W + SIZE_W;   // row * width product
  localparam int OFS_W     = MUL_W + BPP_W;    // byte offset into an image
  localparam int CFG_IDX_W = 1;
  localparam int NSIDE     = 2;
  localparam int SIDE_SRC  = 0;
  localparam int SIDE_DST  = 1;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [BPP_W-1:0]  bpp_t;

  localparam size_t MAX_IMG   = SIZE_W'(16384);
  localparam bpp_t  BPP_RESET = BPP_W'(4);
  localparam bpp_t  BPP_MIN   = BPP_W'(1);
  localparam bpp_t  BPP_MAX   = BPP_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_BPP = 1'b0,
    REG_DST_BPP = 1'b1
  } cfg_reg_t;

  // clipped rectangle, all edges inclusive and inside the image
  typedef struct packed {
    pix_t x1;
    pix_t y1;
    pix_t x2;
    pix_t y2;
  } rect_t;

  function automatic size_t sat_size(input size_t v);
    return (v > MAX_IMG) ? MAX_IMG : v;
  endfunction

  function automatic bpp_t sat_bpp(input bpp_t v);
    bpp_t r;
    r = v;
    if (v == '0) begin
      r = BPP_MIN;
    end else if (v > BPP_MAX) begin
      r = BPP_MAX;
    end
    return r;
  endfunction

endpackage

>>> design/brca_req_if.sv
// ----------------------------------------------------------------------------
// brca_req_if: paste request channel
// Valid/ready channel carrying one paste request per transaction.
// ----------------------------------------------------------------------------
interface brca_req_if #(
  parameter int COORD_BITS = 16,
  parameter int ADDR_BITS  = 32
) ();
  import brca_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [SIZE_W-1:0]            src_img_width;
  logic [SIZE_W-1:0]            src_img_height;
  logic [ADDR_BITS-1:0]         src_base_addr;
  logic signed [COORD_BITS-1:0] src_left;
  logic signed [COORD_BITS-1:0] src_top;
  logic signed [COORD_BITS-1:0] src_right;
  logic signed [COORD_BITS-1:0] src_bottom;
  logic [SIZE_W-1:0]            dst_img_width;
  logic [SIZE_W-1:0]            dst_img_height;
  logic [ADDR_BITS-1:0]         dst_base_addr;
  logic signed [COORD_BITS-1:0] dst_left;
  logic signed [COORD_BITS-1:0] dst_top;

  modport source (
    output valid, src_img_width, src_img_height, src_base_addr,
           src_left, src_top, src_right, src_bottom,
           dst_img_width, dst_img_height, dst_base_addr, dst_left, dst_top,
    input  ready
  );

  modport sink (
    input  valid, src_img_width, src_img_height, src_base_addr,
           src_left, src_top, src_right, src_bottom,
           dst_img_width, dst_img_height, dst_base_addr, dst_left, dst_top,
    output ready
  );
endinterface

>>> design/brca_res_if.sv
// ----------------------------------------------------------------------------
// brca_res_if: paste setup result channel
// Valid/ready channel carrying one clip and address result per transaction.
// ----------------------------------------------------------------------------
interface brca_res_if #(
  parameter int ADDR_BITS = 32
) ();
  import brca_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 paste_hit;
  logic [ADDR_BITS-1:0] src_first_row_addr;
  logic [ADDR_BITS-1:0] src_last_row_addr;
  logic [SPAN_W-1:0]    src_row_bytes;
  logic [PITCH_W-1:0]   src_row_pitch;
  logic [ADDR_BITS-1:0] dst_first_row_addr;
  logic [ADDR_BITS-1:0] dst_last_row_addr;
  logic [SPAN_W-1:0]    dst_row_bytes;
  logic [PITCH_W-1:0]   dst_row_pitch;

  modport source (
    output valid, paste_hit, src_first_row_addr, src_last_row_addr,
           src_row_bytes, src_row_pitch, dst_first_row_addr,
           dst_last_row_addr, dst_row_bytes, dst_row_pitch,
    input  ready
  );

  modport sink (
    input  valid, paste_hit, src_first_row_addr, src_last_row_addr,
           src_row_bytes, src_row_pitch, dst_first_row_addr,
           dst_last_row_addr, dst_row_bytes, dst_row_pitch,
    output ready
  );
endinterface

>>> design/blit_rect_clip_address_unit.sv
// ----------------------------------------------------------------------------
// blit_rect_clip_address_unit: blitter rectangle clip and address setup
// Pipeline: six registered stages from request transaction to result valid.
// Throughput: one request per cycle; a stalled output only holds the stages
// behind it.
// Reset: pipeline valid bits clear, both bytes-per-pixel registers return to 4.
// ----------------------------------------------------------------------------
module blit_rect_clip_address_unit #(
  parameter int COORD_BITS = 16,
  parameter int ADDR_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  brca_req_if.sink                        req,
  brca_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [brca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brca_pkg::BPP_W-1:0]      cfg_wdata
);
  import brca_pkg::*;

  // signed working width: covers the input coordinates and the image sizes
  localparam int CW     = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 3;
  localparam int NSTAGE = 6;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam crd_t ONE_S = CW'(1);

  typedef struct {
    logic  miss;
    size_t sw;
    size_t dw;
    size_t dh;
    addr_t sbase;
    addr_t dbase;
    crd_t  sx1;
    crd_t  sy1;
    crd_t  dx1;
    crd_t  dy1;
    crd_t  ofsx;
    crd_t  ofsy;
    crd_t  wx;
    crd_t  wy;
  } st1_t;

  typedef struct {
    logic  miss;
    size_t sw;
    size_t dw;
    size_t dh;
    addr_t sbase;
    addr_t dbase;
    crd_t  sx1;
    crd_t  sy1;
    crd_t  dx1;
    crd_t  dy1;
    crd_t  dx2;
    crd_t  dy2;
  } st2_t;

  typedef struct {
    logic  hit;
    size_t w    [NSIDE];
    addr_t base [NSIDE];
    rect_t r    [NSIDE];
  } st3_t;

  typedef struct {
    logic             hit;
    addr_t            base [NSIDE];
    logic [MUL_W-1:0] ya   [NSIDE];
    logic [MUL_W-1:0] yb   [NSIDE];
    pix_t             x1   [NSIDE];
    size_t            px   [NSIDE];
    size_t            w    [NSIDE];
  } st4_t;

  typedef struct {
    logic              hit;
    addr_t             base   [NSIDE];
    logic [MUL_W-1:0]  ta     [NSIDE];
    logic [MUL_W-1:0]  tb     [NSIDE];
    logic [SPAN_W-1:0] span   [NSIDE];
    logic [SPAN_W-1:0] imgrow [NSIDE];
  } st5_t;

  typedef struct {
    logic               hit;
    addr_t              first [NSIDE];
    addr_t              last  [NSIDE];
    logic [SPAN_W-1:0]  rbytes[NSIDE];
    logic [PITCH_W-1:0] pitch [NSIDE];
  } st6_t;

  bpp_t src_bpp;
  bpp_t dst_bpp;
  bpp_t bpp [NSIDE];

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  st4_t s4, s4_next;
  st5_t s5, s5_next;
  st6_t s6, s6_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_bpp <= BPP_RESET;
      dst_bpp <= BPP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_BPP: src_bpp <= cfg_wdata;
        REG_DST_BPP: dst_bpp <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign bpp[SIDE_SRC] = sat_bpp(src_bpp);
  assign bpp[SIDE_DST] = sat_bpp(dst_bpp);

  // stage enables: a stage loads when empty or when the one ahead moves
  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || res.ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req.valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: clip the source rectangle to the source image
  always_comb begin
    crd_t  sx1, sy1, sx2, sy2, swm1, shm1, sx2c, sy2c;
    size_t sw, sh;
    logic  inv;
    sw   = sat_size(req.src_img_width);
    sh   = sat_size(req.src_img_height);
    sx1  = crd_t'(req.src_left);
    sy1  = crd_t'(req.src_top);
    sx2  = crd_t'(req.src_right);
    sy2  = crd_t'(req.src_bottom);
    swm1 = crd_t'(sw) - ONE_S;
    shm1 = crd_t'(sh) - ONE_S;
    inv  = (sx1 > sx2) || (sy1 > sy2);
    sx2c = (sx2 > swm1) ? swm1 : sx2;
    sy2c = (sy2 > shm1) ? shm1 : sy2;

    s1_next.miss  = inv || (sw == '0) || (sh == '0) || (sx1 > swm1) || sx2[CW-1] ||
                    (sy1 > shm1) || sy2[CW-1];
    s1_next.sw    = sw;
    s1_next.dw    = sat_size(req.dst_img_width);
    s1_next.dh    = sat_size(req.dst_img_height);
    s1_next.sbase = req.src_base_addr;
    s1_next.dbase = req.dst_base_addr;
    s1_next.sx1   = sx1[CW-1] ? '0 : sx1;
    s1_next.sy1   = sy1[CW-1] ? '0 : sy1;
    s1_next.dx1   = crd_t'(req.dst_left);
    s1_next.dy1   = crd_t'(req.dst_top);
    // how far the source corner moved in
    s1_next.ofsx  = sx1[CW-1] ? ('0 - sx1) : '0;
    s1_next.ofsy  = sy1[CW-1] ? ('0 - sy1) : '0;
    // far edge relative to the unclipped corner
    s1_next.wx    = sx2c - sx1;
    s1_next.wy    = sy2c - sy1;
  end

  // stage 2: move the destination rectangle by the source clip
  always_comb begin
    s2_next.miss  = s1.miss;
    s2_next.sw    = s1.sw;
    s2_next.dw    = s1.dw;
    s2_next.dh    = s1.dh;
    s2_next.sbase = s1.sbase;
    s2_next.dbase = s1.dbase;
    s2_next.sx1   = s1.sx1;
    s2_next.sy1   = s1.sy1;
    s2_next.dx1   = s1.dx1 + s1.ofsx;
    s2_next.dy1   = s1.dy1 + s1.ofsy;
    s2_next.dx2   = s1.dx1 + s1.wx;
    s2_next.dy2   = s1.dy1 + s1.wy;
  end

  // stage 3: clip the destination, pull the source in to match
  always_comb begin
    crd_t dwm1, dhm1, dx1c, dy1c, dx2c, dy2c, sx1f, sy1f, sx2f, sy2f;
    dwm1 = crd_t'(s2.dw) - ONE_S;
    dhm1 = crd_t'(s2.dh) - ONE_S;
    dx1c = s2.dx1[CW-1] ? '0 : s2.dx1;
    dy1c = s2.dy1[CW-1] ? '0 : s2.dy1;
    dx2c = (s2.dx2 > dwm1) ? dwm1 : s2.dx2;
    dy2c = (s2.dy2 > dhm1) ? dhm1 : s2.dy2;
    sx1f = s2.dx1[CW-1] ? (s2.sx1 - s2.dx1) : s2.sx1;
    sy1f = s2.dy1[CW-1] ? (s2.sy1 - s2.dy1) : s2.sy1;
    sx2f = s2.sx1 + dx2c - s2.dx1;
    sy2f = s2.sy1 + dy2c - s2.dy1;

    s3_next.hit = !(s2.miss || (s2.dw == '0) || (s2.dh == '0) || (s2.dx1 > dwm1) ||
                    s2.dx2[CW-1] || (s2.dy1 > dhm1) || s2.dy2[CW-1]);
    s3_next.w[SIDE_SRC]    = s2.sw;
    s3_next.w[SIDE_DST]    = s2.dw;
    s3_next.base[SIDE_SRC] = s2.sbase;
    s3_next.base[SIDE_DST] = s2.dbase;
    s3_next.r[SIDE_SRC].x1 = sx1f[PIX_W-1:0];
    s3_next.r[SIDE_SRC].y1 = sy1f[PIX_W-1:0];
    s3_next.r[SIDE_SRC].x2 = sx2f[PIX_W-1:0];
    s3_next.r[SIDE_SRC].y2 = sy2f[PIX_W-1:0];
    s3_next.r[SIDE_DST].x1 = dx1c[PIX_W-1:0];
    s3_next.r[SIDE_DST].y1 = dy1c[PIX_W-1:0];
    s3_next.r[SIDE_DST].x2 = dx2c[PIX_W-1:0];
    s3_next.r[SIDE_DST].y2 = dy2c[PIX_W-1:0];
  end

  // stage 4: row index times image width, and pixels per row
  always_comb begin
    s4_next.hit = s3.hit;
    for (int i = 0; i < NSIDE; i++) begin
      s4_next.base[i] = s3.base[i];
      s4_next.ya[i]   = MUL_W'(s3.r[i].y1) * MUL_W'(s3.w[i]);
      s4_next.yb[i]   = MUL_W'(s3.r[i].y2) * MUL_W'(s3.w[i]);
      s4_next.x1[i]   = s3.r[i].x1;
      s4_next.px[i]   = {1'b0, s3.r[i].x2} - {1'b0, s3.r[i].x1} + SIZE_W'(1);
      s4_next.w[i]    = s3.w[i];
    end
  end

  // stage 5: pixel index, span and full row in bytes
  always_comb begin
    s5_next.hit = s4.hit;
    for (int i = 0; i < NSIDE; i++) begin
      s5_next.base[i]   = s4.base[i];
      s5_next.ta[i]     = s4.ya[i] + MUL_W'(s4.x1[i]);
      s5_next.tb[i]     = s4.yb[i] + MUL_W'(s4.x1[i]);
      s5_next.span[i]   = SPAN_W'(s4.px[i]) * SPAN_W'(bpp[i]);
      s5_next.imgrow[i] = SPAN_W'(s4.w[i]) * SPAN_W'(bpp[i]);
    end
  end

  // stage 6: byte addresses; a miss zeroes the whole result
  always_comb begin
    logic [OFS_W-1:0]  ofs_a, ofs_b;
    logic [SPAN_W-1:0] diff;
    s6_next.hit = s5.hit;
    for (int i = 0; i < NSIDE; i++) begin
      ofs_a = OFS_W'(s5.ta[i]) * OFS_W'(bpp[i]);
      ofs_b = OFS_W'(s5.tb[i]) * OFS_W'(bpp[i]);
      diff  = s5.imgrow[i] - s5.span[i];
      if (s5.hit) begin
        s6_next.first[i]  = s5.base[i] + ADDR_BITS'(ofs_a);
        s6_next.last[i]   = s5.base[i] + ADDR_BITS'(ofs_b);
        s6_next.rbytes[i] = s5.span[i];
        s6_next.pitch[i]  = diff[PITCH_W-1:0];
      end else begin
        s6_next.first[i]  = '0;
        s6_next.last[i]   = '0;
        s6_next.rbytes[i] = '0;
        s6_next.pitch[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1 <= s1_next;
    if (en[1]) s2 <= s2_next;
    if (en[2]) s3 <= s3_next;
    if (en[3]) s4 <= s4_next;
    if (en[4]) s5 <= s5_next;
    if (en[5]) s6 <= s6_next;
  end

  assign res.valid              = v[NSTAGE-1];
  assign res.paste_hit          = s6.hit;
  assign res.src_first_row_addr = s6.first[SIDE_SRC];
  assign res.src_last_row_addr  = s6.last[SIDE_SRC];
  assign res.src_row_bytes      = s6.rbytes[SIDE_SRC];
  assign res.src_row_pitch      = s6.pitch[SIDE_SRC];
  assign res.dst_first_row_addr = s6.first[SIDE_DST];
  assign res.dst_last_row_addr  = s6.last[SIDE_DST];
  assign res.dst_row_bytes      = s6.rbytes[SIDE_DST];
  assign res.dst_row_pitch      = s6.pitch[SIDE_DST];

  // an open output slot always lets a new transaction in
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (!res.valid || res.ready) |-> req.ready)
    else $error("input stalled while output side can move");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.paste_hit) |->
      (res.src_first_row_addr == '0) && (res.dst_last_row_addr == '0) &&
      (res.src_row_bytes == '0) && (res.dst_row_pitch == '0))
    else $error("miss result carries nonzero fields");

  // a hit always covers at least one pixel on both sides
  a_hit_span: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.paste_hit) |->
      (res.src_row_bytes != '0) && (res.dst_row_bytes != '0))
    else $error("hit result with empty span");

endmodule
